@@ rtl/tuple_keyed_hash_accumulator_assert.svh @@
// Assertion macros for the tuple keyed hash accumulator.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef TUPLE_KEYED_HASH_ACCUMULATOR_ASSERT_SVH
`define TUPLE_KEYED_HASH_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTH
`define THKA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
`define THKA_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition");
`else
`define THKA_ASSERT(lbl, prop)
`define THKA_NEVER(lbl, cond)
`endif
`endif

@@ rtl/thka_pkg.sv @@
// Shared types and constants of the tuple keyed hash accumulator.
// No dependencies.
package thka_pkg;

  localparam int BUCKETS = 1024;
  localparam int NODES   = 1024;

  localparam int BKT_AW  = $clog2(BUCKETS);
  localparam int BKT_CW  = $clog2(BUCKETS + 1);
  localparam int NODE_AW = $clog2(NODES);
  localparam int LINK_W  = $clog2(NODES + 1);
  localparam int KEY_W   = 128;

  localparam logic [63:0] SEED      = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MUL_A     = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MUL_B     = 64'hc4ceb9fe1a85ec53;
  localparam int          FIN_SHIFT = 33;

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_GET  = 2'd1;
  localparam logic [1:0] REQ_ITER = 2'd2;

  typedef struct packed {
    logic              done;
    logic [BKT_AW-1:0] bucket;
  } hash_rsp_t;

  typedef struct packed {
    logic             status;
    logic             found;
    logic [31:0]      value;
    logic [3:0][31:0] key;
  } res_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HEAD_WAIT,
    ST_WALK,
    ST_CMP,
    ST_ACT,
    ST_UPD,
    ST_FREE,
    ST_ALLOC,
    ST_ALLOC_WAIT,
    ST_INSERT,
    ST_IT_START,
    ST_IT_LINK,
    ST_IT_SCAN,
    ST_IT_HEAD,
    ST_IT_EMIT,
    ST_IT_DATA,
    ST_RESP
  } state_e;

endpackage

@@ rtl/thka_if.sv @@
// Request and response channel interfaces of the tuple keyed hash accumulator.
// No dependencies.
interface thka_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] key_a;
  logic signed [31:0] key_b;
  logic signed [31:0] key_c;
  logic signed [31:0] key_d;
  logic signed [31:0] delta;
  logic               iter_restart;

  modport source (output valid, req_type, key_a, key_b, key_c, key_d, delta, iter_restart,
                  input ready);
  modport sink (input valid, req_type, key_a, key_b, key_c, key_d, delta, iter_restart,
                output ready);
endinterface

interface thka_rsp_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic               found;
  logic signed [31:0] value;
  logic signed [31:0] out_key_a;
  logic signed [31:0] out_key_b;
  logic signed [31:0] out_key_c;
  logic signed [31:0] out_key_d;

  modport source (output valid, status, found, value, out_key_a, out_key_b, out_key_c,
                  out_key_d, input ready);
  modport sink (input valid, status, found, value, out_key_a, out_key_b, out_key_c,
                out_key_d, output ready);
endinterface

@@ rtl/thka_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module thka_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/thka_hash.sv @@
// Iterative key hash: four rounds of xor plus 64-bit multiply-xorshift finalizer.
// One shared 32x32 multiplier, three partial products per 64-bit multiply. Uses thka_pkg.
`include "tuple_keyed_hash_accumulator_assert.svh"

module thka_hash (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [3:0][31:0]      words_i,
  output thka_pkg::hash_rsp_t   rsp_o
);

  localparam logic [1:0] LAST_PART  = 2'd2;
  localparam logic [1:0] LAST_ROUND = 2'd3;

  logic        busy_q, done_q, mulsel_q;
  logic [1:0]  round_q, part_q;
  logic [63:0] x_q, acc_q, acc_d;
  logic [63:0] acc_mix, seed_mix, pre, op0, opnow, coef, prod;
  logic [31:0] mul_a, mul_b;

  always_comb begin
    acc_mix  = acc_q ^ (acc_q >> thka_pkg::FIN_SHIFT);
    seed_mix = (round_q == 2'd0) ? thka_pkg::SEED : acc_mix;
    pre      = seed_mix ^ {32'b0, words_i[round_q]};
    op0      = pre ^ (pre >> thka_pkg::FIN_SHIFT);
    opnow    = mulsel_q ? acc_mix : op0;
    coef     = mulsel_q ? thka_pkg::MUL_B : thka_pkg::MUL_A;
    case (part_q)
      2'd0: begin
        mul_a = opnow[31:0];
        mul_b = coef[31:0];
      end
      2'd1: begin
        mul_a = x_q[31:0];
        mul_b = coef[63:32];
      end
      default: begin
        mul_a = x_q[63:32];
        mul_b = coef[31:0];
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign acc_d = (part_q == 2'd0) ? prod : acc_q + {prod[31:0], 32'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      round_q  <= '0;
      mulsel_q <= 1'b0;
      part_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q   <= 1'b1;
        round_q  <= '0;
        mulsel_q <= 1'b0;
        part_q   <= '0;
      end else if (busy_q) begin
        if (part_q == LAST_PART) begin
          part_q   <= '0;
          mulsel_q <= ~mulsel_q;
          if (mulsel_q) begin
            if (round_q == LAST_ROUND) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end else begin
              round_q <= round_q + 2'd1;
            end
          end
        end else begin
          part_q <= part_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      if (part_q == 2'd0) begin
        x_q <= opnow;
      end
      acc_q <= acc_d;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.bucket = acc_mix[thka_pkg::BKT_AW-1:0];

  `THKA_NEVER(a_start_busy, start_i && busy_q)
  `THKA_ASSERT(a_done_pulse, done_q |=> !done_q)
  `THKA_ASSERT(a_start_runs, start_i |=> busy_q)

endmodule

@@ rtl/tuple_keyed_hash_accumulator.sv @@
// Tuple keyed hash accumulator: hash table of signed 32-bit counters keyed by four words.
// Uses thka_pkg, thka_if (thka_req_if, thka_rsp_if), thka_hash and thka_ram.
//
// Usage:
//   req_i carries one request per beat: add delta, get value or iterate next entry.
//   rsp_o returns exactly one result beat per request, in request order.
//   Requests are handled one at a time; req_i.ready is high only while idle.
//   The hash runs eight 64-bit multiplies on one 32x32 multiplier, three partial
//   products each; then the bucket head is read, the chain is walked node by node,
//   and the block decides and updates or inserts. Iterate scans the buckets one by
//   one and reads the found node. The result then moves into the output register.
//   After reset the bucket head store is cleared, one entry a cycle, with req_i.ready
//   low until all 1024 entries are cleared. Node storage is not cleared.
//   The result sits in an output register; the block accepts the next request while
//   it waits. If rsp_o stalls and a second result is done, the block holds it and
//   stays busy until the output register frees.
`include "tuple_keyed_hash_accumulator_assert.svh"

module tuple_keyed_hash_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  thka_req_if.sink    req_i,
  thka_rsp_if.source  rsp_o
);

  localparam int BKT_AW  = thka_pkg::BKT_AW;
  localparam int BKT_CW  = thka_pkg::BKT_CW;
  localparam int NODE_AW = thka_pkg::NODE_AW;
  localparam int LINK_W  = thka_pkg::LINK_W;
  localparam int KEY_W   = thka_pkg::KEY_W;

  function automatic logic [NODE_AW-1:0] node_addr(input logic [LINK_W-1:0] l);
    logic [LINK_W-1:0] t;
    t = l - LINK_W'(1);
    return t[NODE_AW-1:0];
  endfunction

  thka_pkg::state_e state_q, state_d;
  logic [BKT_AW-1:0]  clr_q, clr_d, bucket_q, bucket_d;
  logic [1:0]         req_q, req_d;
  logic [3:0][31:0]   key_q, key_d;
  logic [31:0]        delta_q, delta_d, val_q, val_d, sum;
  logic [LINK_W-1:0]  head_q, head_d, cur_q, cur_d, prev_q, prev_d, nxt_q, nxt_d;
  logic [LINK_W-1:0]  free_q, free_d, fresh_q, fresh_d, inode_q, inode_d, slot_q, slot_d;
  logic [BKT_CW-1:0]  ib_q, ib_d;
  logic               found_q, found_d;
  thka_pkg::res_t     res_q, res_d, out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic                accept, hash_start;
  thka_pkg::hash_rsp_t hrsp;

  logic               bkt_we;
  logic [BKT_AW-1:0]  bkt_waddr, bkt_raddr;
  logic [LINK_W-1:0]  bkt_wdata, bkt_rdata;
  logic               key_we, val_we, link_we;
  logic [NODE_AW-1:0] node_waddr, link_waddr, node_raddr;
  logic [31:0]        val_wdata, val_rdata;
  logic [LINK_W-1:0]  link_wdata, link_rdata;
  logic [KEY_W-1:0]   key_rdata;
  logic               key_match;

  assign accept     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == thka_pkg::ST_IDLE);
  assign hash_start = accept &&
                      (req_i.req_type == thka_pkg::REQ_ADD || req_i.req_type == thka_pkg::REQ_GET);
  assign sum        = val_q + delta_q;
  assign key_match  = (key_rdata == key_q);

  thka_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .words_i (key_d),
    .rsp_o   (hrsp)
  );

  thka_ram #(.W(LINK_W), .D(thka_pkg::BUCKETS)) u_bkt_ram (
    .clk_i (clk_i), .we_i (bkt_we), .waddr_i (bkt_waddr), .wdata_i (bkt_wdata),
    .raddr_i (bkt_raddr), .rdata_o (bkt_rdata)
  );

  thka_ram #(.W(KEY_W), .D(thka_pkg::NODES)) u_key_ram (
    .clk_i (clk_i), .we_i (key_we), .waddr_i (node_waddr), .wdata_i (key_q),
    .raddr_i (node_raddr), .rdata_o (key_rdata)
  );

  thka_ram #(.W(32), .D(thka_pkg::NODES)) u_val_ram (
    .clk_i (clk_i), .we_i (val_we), .waddr_i (node_waddr), .wdata_i (val_wdata),
    .raddr_i (node_raddr), .rdata_o (val_rdata)
  );

  thka_ram #(.W(LINK_W), .D(thka_pkg::NODES)) u_link_ram (
    .clk_i (clk_i), .we_i (link_we), .waddr_i (link_waddr), .wdata_i (link_wdata),
    .raddr_i (node_raddr), .rdata_o (link_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      thka_pkg::ST_CLEAR: if (clr_q == '1) state_d = thka_pkg::ST_IDLE;
      thka_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          case (req_i.req_type)
            thka_pkg::REQ_ADD, thka_pkg::REQ_GET: state_d = thka_pkg::ST_HASH;
            thka_pkg::REQ_ITER:                   state_d = thka_pkg::ST_IT_START;
            default:                              state_d = thka_pkg::ST_RESP;
          endcase
        end
      end
      thka_pkg::ST_HASH:      if (hrsp.done) state_d = thka_pkg::ST_HEAD_WAIT;
      thka_pkg::ST_HEAD_WAIT: begin
        state_d = (bkt_rdata == '0) ? thka_pkg::ST_ACT : thka_pkg::ST_WALK;
      end
      thka_pkg::ST_WALK:      state_d = thka_pkg::ST_CMP;
      thka_pkg::ST_CMP: begin
        if (key_match || link_rdata == '0) state_d = thka_pkg::ST_ACT;
        else                               state_d = thka_pkg::ST_WALK;
      end
      thka_pkg::ST_ACT: begin
        if (req_q == thka_pkg::REQ_GET || delta_q == '0) state_d = thka_pkg::ST_RESP;
        else if (found_q)                                state_d = thka_pkg::ST_UPD;
        else if (free_q != '0)                           state_d = thka_pkg::ST_ALLOC;
        else if (fresh_q < LINK_W'(thka_pkg::NODES))     state_d = thka_pkg::ST_INSERT;
        else                                             state_d = thka_pkg::ST_RESP;
      end
      thka_pkg::ST_UPD: begin
        state_d = (sum == '0) ? thka_pkg::ST_FREE : thka_pkg::ST_RESP;
      end
      thka_pkg::ST_FREE:       state_d = thka_pkg::ST_RESP;
      thka_pkg::ST_ALLOC:      state_d = thka_pkg::ST_ALLOC_WAIT;
      thka_pkg::ST_ALLOC_WAIT: state_d = thka_pkg::ST_INSERT;
      thka_pkg::ST_INSERT:     state_d = thka_pkg::ST_RESP;
      thka_pkg::ST_IT_START: begin
        state_d = (inode_q != '0) ? thka_pkg::ST_IT_LINK : thka_pkg::ST_IT_SCAN;
      end
      thka_pkg::ST_IT_LINK: begin
        state_d = (link_rdata == '0) ? thka_pkg::ST_IT_SCAN : thka_pkg::ST_IT_EMIT;
      end
      thka_pkg::ST_IT_SCAN: begin
        state_d = (ib_q < BKT_CW'(thka_pkg::BUCKETS)) ? thka_pkg::ST_IT_HEAD
                                                      : thka_pkg::ST_RESP;
      end
      thka_pkg::ST_IT_HEAD: begin
        state_d = (bkt_rdata != '0) ? thka_pkg::ST_IT_EMIT : thka_pkg::ST_IT_SCAN;
      end
      thka_pkg::ST_IT_EMIT: state_d = thka_pkg::ST_IT_DATA;
      thka_pkg::ST_IT_DATA: state_d = thka_pkg::ST_RESP;
      thka_pkg::ST_RESP: if (!out_valid_q || rsp_o.ready) state_d = thka_pkg::ST_IDLE;
      default: state_d = thka_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_d    = clr_q;
    bucket_d = bucket_q;
    req_d    = req_q;
    key_d    = key_q;
    delta_d  = delta_q;
    val_d    = val_q;
    head_d   = head_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    nxt_d    = nxt_q;
    free_d   = free_q;
    fresh_d  = fresh_q;
    inode_d  = inode_q;
    slot_d   = slot_q;
    ib_d     = ib_q;
    found_d  = found_q;
    res_d    = res_q;

    bkt_we     = 1'b0;
    bkt_waddr  = bucket_q;
    bkt_wdata  = slot_q;
    bkt_raddr  = hrsp.bucket;
    key_we     = 1'b0;
    val_we     = 1'b0;
    link_we    = 1'b0;
    node_waddr = node_addr(slot_q);
    link_waddr = node_addr(slot_q);
    val_wdata  = delta_q;
    link_wdata = head_q;
    node_raddr = node_addr(cur_q);

    case (state_q)
      thka_pkg::ST_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_q;
        bkt_wdata = '0;
        clr_d     = clr_q + BKT_AW'(1);
      end
      thka_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          req_d   = req_i.req_type;
          key_d   = {req_i.key_d, req_i.key_c, req_i.key_b, req_i.key_a};
          delta_d = req_i.delta;
          res_d   = '0;
          found_d = 1'b0;
          if (req_i.req_type == thka_pkg::REQ_ITER && req_i.iter_restart) begin
            ib_d    = '0;
            inode_d = '0;
          end
        end
      end
      thka_pkg::ST_HASH: begin
        if (hrsp.done) bucket_d = hrsp.bucket;
      end
      thka_pkg::ST_HEAD_WAIT: begin
        head_d = bkt_rdata;
        cur_d  = bkt_rdata;
        prev_d = '0;
      end
      thka_pkg::ST_CMP: begin
        if (key_match) begin
          found_d = 1'b1;
          val_d   = val_rdata;
          nxt_d   = link_rdata;
        end else begin
          prev_d = cur_q;
          cur_d  = link_rdata;
        end
      end
      thka_pkg::ST_ACT: begin
        if (req_q == thka_pkg::REQ_GET) begin
          res_d.found = found_q;
          res_d.value = found_q ? val_q : '0;
        end else if (delta_q != '0 && !found_q && free_q == '0) begin
          if (fresh_q < LINK_W'(thka_pkg::NODES)) begin
            slot_d  = fresh_q + LINK_W'(1);
            fresh_d = fresh_q + LINK_W'(1);
          end else begin
            res_d.status = 1'b1;
          end
        end
      end
      thka_pkg::ST_UPD: begin
        val_we     = 1'b1;
        node_waddr = node_addr(cur_q);
        val_wdata  = sum;
        if (sum == '0) begin
          if (prev_q != '0) begin
            link_we    = 1'b1;
            link_waddr = node_addr(prev_q);
            link_wdata = nxt_q;
          end else begin
            bkt_we    = 1'b1;
            bkt_wdata = nxt_q;
          end
          if (inode_q == cur_q) inode_d = prev_q;
        end
      end
      thka_pkg::ST_FREE: begin
        link_we    = 1'b1;
        link_waddr = node_addr(cur_q);
        link_wdata = free_q;
        free_d     = cur_q;
      end
      thka_pkg::ST_ALLOC: begin
        node_raddr = node_addr(free_q);
      end
      thka_pkg::ST_ALLOC_WAIT: begin
        slot_d = free_q;
        free_d = link_rdata;
      end
      thka_pkg::ST_INSERT: begin
        key_we  = 1'b1;
        val_we  = 1'b1;
        link_we = 1'b1;
        bkt_we  = 1'b1;
      end
      thka_pkg::ST_IT_START: begin
        node_raddr = node_addr(inode_q);
      end
      thka_pkg::ST_IT_LINK: begin
        inode_d = link_rdata;
        if (link_rdata == '0 && ib_q < BKT_CW'(thka_pkg::BUCKETS)) ib_d = ib_q + BKT_CW'(1);
      end
      thka_pkg::ST_IT_SCAN: begin
        bkt_raddr = ib_q[BKT_AW-1:0];
      end
      thka_pkg::ST_IT_HEAD: begin
        if (bkt_rdata != '0) inode_d = bkt_rdata;
        else                 ib_d    = ib_q + BKT_CW'(1);
      end
      thka_pkg::ST_IT_EMIT: begin
        node_raddr = node_addr(inode_q);
      end
      thka_pkg::ST_IT_DATA: begin
        res_d.found = 1'b1;
        res_d.value = val_rdata;
        res_d.key   = key_rdata;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    if (state_q == thka_pkg::ST_RESP && (!out_valid_q || rsp_o.ready)) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= thka_pkg::ST_CLEAR;
      clr_q       <= '0;
      free_q      <= '0;
      fresh_q     <= '0;
      ib_q        <= '0;
      inode_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_q      <= free_d;
      fresh_q     <= fresh_d;
      ib_q        <= ib_d;
      inode_q     <= inode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bucket_q <= bucket_d;
    req_q    <= req_d;
    key_q    <= key_d;
    delta_q  <= delta_d;
    val_q    <= val_d;
    head_q   <= head_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    nxt_q    <= nxt_d;
    slot_q   <= slot_d;
    found_q  <= found_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_q.status;
  assign rsp_o.found     = out_q.found;
  assign rsp_o.value     = out_q.value;
  assign rsp_o.out_key_a = out_q.key[0];
  assign rsp_o.out_key_b = out_q.key[1];
  assign rsp_o.out_key_c = out_q.key[2];
  assign rsp_o.out_key_d = out_q.key[3];

  `THKA_ASSERT(a_accept_leaves_idle, accept |=> state_q != thka_pkg::ST_IDLE)
  `THKA_ASSERT(a_insert_slot, state_q == thka_pkg::ST_INSERT |-> slot_q != '0)
  `THKA_ASSERT(a_update_found, state_q == thka_pkg::ST_UPD |-> found_q)
  `THKA_ASSERT(a_emit_node, state_q == thka_pkg::ST_IT_EMIT |-> inode_q != '0)

endmodule

@@ test/tuple_keyed_hash_accumulator_tb.sv @@
// Testbench for tuple_keyed_hash_accumulator: adds, gets, iterates and spare-type requests
// against a cycle-free table predictor, with random idling and a long response stall.
// Depends on thka_pkg, thka_if and the block RTL.
module tuple_keyed_hash_accumulator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef logic [31:0] key_t [4];

  typedef struct {
    logic        status;
    logic        found;
    logic [31:0] value;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] kc;
    logic [31:0] kd;
  } table_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  thka_req_if req ();
  thka_rsp_if rsp ();

  tuple_keyed_hash_accumulator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always #1 clk_i = ~clk_i;

  // table predictor state; links use 0 for none, n for node n-1
  int unsigned      head_tbl [thka_pkg::BUCKETS];
  logic [63:0]      node_lo  [thka_pkg::NODES];
  logic [63:0]      node_hi  [thka_pkg::NODES];
  logic [31:0]      node_val [thka_pkg::NODES];
  int unsigned      node_nxt [thka_pkg::NODES];
  int unsigned      free_top;
  int unsigned      fresh_cnt;
  int unsigned      live_cnt;
  int unsigned      walk_bkt;
  int unsigned      walk_node;

  table_res_t       pending_q [$];
  table_res_t       last_res;
  int               err_cnt = 0;
  bit               idle_on = 1'b1;
  int               hold_left = 0;
  int               gap_left = 0;
  logic [31:0]      key_pool [24][4];

  function automatic bit link_ok(int unsigned l);
    return l != 0 && l <= thka_pkg::NODES;
  endfunction

  function automatic logic [63:0] mix64(logic [63:0] x);
    x ^= x >> thka_pkg::FIN_SHIFT;
    x = x * thka_pkg::MUL_A;
    x ^= x >> thka_pkg::FIN_SHIFT;
    x = x * thka_pkg::MUL_B;
    x ^= x >> thka_pkg::FIN_SHIFT;
    return x;
  endfunction

  function automatic int unsigned bucket_of_key(logic [31:0] k [4]);
    logic [63:0] h;
    h = thka_pkg::SEED;
    for (int w = 0; w < 4; w++) h = mix64(h ^ {32'd0, k[w]});
    return 32'(h % thka_pkg::BUCKETS);
  endfunction

  function automatic int unsigned find_slot(logic [31:0] k [4], output int unsigned prev);
    int unsigned cur;
    cur = head_tbl[bucket_of_key(k)];
    prev = 0;
    while (link_ok(cur)) begin
      if (node_lo[cur-1] == {k[1], k[0]} && node_hi[cur-1] == {k[3], k[2]}) return cur;
      prev = cur;
      cur = node_nxt[cur-1];
    end
    return 0;
  endfunction

  function automatic table_res_t predict_table(logic [1:0] kind, logic [31:0] k [4],
                                               logic [31:0] dlt, logic rst_walk);
    table_res_t  r;
    int unsigned b, cur, prev, slot, n;
    r = '{default: '0};
    if (kind == thka_pkg::REQ_ADD || kind == thka_pkg::REQ_GET) begin
      b = bucket_of_key(k);
      cur = find_slot(k, prev);
      if (kind == thka_pkg::REQ_GET) begin
        if (cur != 0) begin
          r.found = 1'b1;
          r.value = node_val[cur-1];
        end
      end else if (dlt != 0) begin
        if (cur != 0) begin
          n = cur - 1;
          node_val[n] += dlt;
          if (node_val[n] == 0) begin
            if (prev != 0) node_nxt[prev-1] = node_nxt[n];
            else head_tbl[b] = node_nxt[n];
            if (walk_node == cur) walk_node = prev;
            node_nxt[n] = free_top;
            free_top = cur;
            if (live_cnt > 0) live_cnt--;
          end
        end else begin
          slot = 0;
          if (link_ok(free_top)) begin
            slot = free_top;
            free_top = node_nxt[slot-1];
          end else if (fresh_cnt < thka_pkg::NODES) begin
            fresh_cnt++;
            slot = fresh_cnt;
          end else begin
            r.status = 1'b1;
          end
          if (slot != 0) begin
            node_lo[slot-1] = {k[1], k[0]};
            node_hi[slot-1] = {k[3], k[2]};
            node_val[slot-1] = dlt;
            node_nxt[slot-1] = head_tbl[b];
            head_tbl[b] = slot;
            live_cnt++;
          end
        end
      end
    end else if (kind == thka_pkg::REQ_ITER) begin
      if (rst_walk) begin
        walk_bkt = 0;
        walk_node = 0;
      end
      if (link_ok(walk_node)) begin
        walk_node = node_nxt[walk_node-1];
        if (!link_ok(walk_node)) begin
          walk_node = 0;
          if (walk_bkt < thka_pkg::BUCKETS) walk_bkt++;
        end
      end else begin
        walk_node = 0;
      end
      while (walk_node == 0 && walk_bkt < thka_pkg::BUCKETS) begin
        if (link_ok(head_tbl[walk_bkt])) walk_node = head_tbl[walk_bkt];
        else walk_bkt++;
      end
      if (walk_node != 0) begin
        n = walk_node - 1;
        r.found = 1'b1;
        r.value = node_val[n];
        {r.kb, r.ka} = node_lo[n];
        {r.kd, r.kc} = node_hi[n];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic send_req(logic [1:0] kind, logic [31:0] k [4], logic [31:0] dlt,
                          logic rst_walk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.req_type     <= kind;
    req.key_a        <= k[0];
    req.key_b        <= k[1];
    req.key_c        <= k[2];
    req.key_d        <= k[3];
    req.delta        <= dlt;
    req.iter_restart <= rst_walk;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    last_res = predict_table(kind, k, dlt, rst_walk);
    pending_q.push_back(last_res);
  endtask

  // response side: random stall bursts, plus a long hold when asked
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        rsp.ready <= 1'b0;
        gap_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp.ready <= 1'b0;
        gap_left = $urandom_range(0, 2);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    table_res_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected beat", rsp.value, '0);
      end else begin
        want = pending_q.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (rsp.found !== want.found)
          report_mismatch("found", 32'(rsp.found), 32'(want.found));
        if (rsp.value !== want.value) report_mismatch("value", rsp.value, want.value);
        if (rsp.out_key_a !== want.ka) report_mismatch("out_key_a", rsp.out_key_a, want.ka);
        if (rsp.out_key_b !== want.kb) report_mismatch("out_key_b", rsp.out_key_b, want.kb);
        if (rsp.out_key_c !== want.kc) report_mismatch("out_key_c", rsp.out_key_c, want.kc);
        if (rsp.out_key_d !== want.kd) report_mismatch("out_key_d", rsp.out_key_d, want.kd);
      end
    end
  end

  function automatic void rand_key(output logic [31:0] k [4]);
    for (int w = 0; w < 4; w++) k[w] = $urandom;
  endfunction

  function automatic key_t k3_dummy();
    key_t k;
    rand_key(k);
    return k;
  endfunction

  task automatic test_add_get();
    logic [31:0] k1 [4], k2 [4], k3 [4], kn [4];
    k1 = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    k2 = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    k3 = '{32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000};
    kn = '{32'h0, 32'h0, 32'h0, 32'h0};
    send_req(thka_pkg::REQ_GET, kn, 32'd0, 1'b0);
    send_req(thka_pkg::REQ_ADD, k1, 32'd5, 1'b0);
    send_req(thka_pkg::REQ_ADD, k1, 32'd0, 1'b0);
    send_req(thka_pkg::REQ_GET, k1, 32'd0, 1'b0);
    send_req(thka_pkg::REQ_ADD, k2, 32'h7fff_ffff, 1'b0);
    send_req(thka_pkg::REQ_ADD, k2, 32'd1, 1'b0);
    send_req(thka_pkg::REQ_GET, k2, 32'd0, 1'b0);
    send_req(thka_pkg::REQ_ADD, k3, 32'h8000_0000, 1'b0);
    send_req(thka_pkg::REQ_ADD, kn, 32'hffff_ffff, 1'b0);
    send_req(thka_pkg::REQ_ADD, k1, -32'sd5, 1'b0);
    send_req(thka_pkg::REQ_GET, k1, 32'd0, 1'b0);
    send_req(REQ_SPARE, k2, 32'hffff_ffff, 1'b1);
  endtask

  task automatic test_iterate();
    logic [31:0] k [4];
    send_req(thka_pkg::REQ_ITER, k3_dummy(), 32'd0, 1'b1);
    repeat (4) send_req(thka_pkg::REQ_ITER, k3_dummy(), 32'd0, 1'b0);
    send_req(thka_pkg::REQ_ITER, k3_dummy(), 32'd0, 1'b0);
    send_req(thka_pkg::REQ_ITER, k3_dummy(), 32'd0, 1'b1);
    // drop the entry the walk stands on, then step on
    k = '{last_res.ka, last_res.kb, last_res.kc, last_res.kd};
    send_req(thka_pkg::REQ_ADD, k, -last_res.value, 1'b0);
    send_req(thka_pkg::REQ_ITER, k3_dummy(), 32'd0, 1'b0);
    send_req(thka_pkg::REQ_ITER, k3_dummy(), 32'd0, 1'b0);
  endtask

  task automatic test_random_mix(int count, bit no_idle);
    logic [31:0] k [4];
    logic [31:0] dlt;
    int unsigned r, prev, s;
    for (int i = 0; i < count; i++) begin
      if (!no_idle && i % 60 == 0) idle_on = $urandom_range(0, 3) != 0;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, 23)];
      else rand_key(k);
      if (r < 45) begin
        s = find_slot(k, prev);
        case ($urandom_range(0, 9))
          0, 1, 2: dlt = (s != 0) ? -node_val[s-1] : $urandom;
          3:       dlt = 32'd0;
          4, 5:    dlt = $urandom;
          default: dlt = $urandom_range(0, 40) - 20;
        endcase
        send_req(thka_pkg::REQ_ADD, k, dlt, 1'b0);
      end else if (r < 70) begin
        send_req(thka_pkg::REQ_GET, k, $urandom, 1'($urandom_range(0, 1)));
      end else if (r < 96) begin
        send_req(thka_pkg::REQ_ITER, k, $urandom, $urandom_range(0, 19) == 0);
      end else begin
        send_req(REQ_SPARE, k, $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_long_stall();
    logic [31:0] k [4];
    hold_left = 400;
    for (int i = 0; i < 8; i++) begin
      k = key_pool[i];
      send_req(thka_pkg::REQ_GET, k, 32'd0, 1'b0);
    end
  endtask

  initial begin
    foreach (head_tbl[i]) head_tbl[i] = 0;
    free_top = 0;
    fresh_cnt = 0;
    live_cnt = 0;
    walk_bkt = 0;
    walk_node = 0;
    for (int i = 0; i < 24; i++) begin
      for (int w = 0; w < 4; w++) key_pool[i][w] = (i < 4) ? $urandom_range(0, 3) : $urandom;
    end
    req.valid = 1'b0;
    req.req_type = thka_pkg::REQ_GET;
    req.key_a = '0;
    req.key_b = '0;
    req.key_c = '0;
    req.key_d = '0;
    req.delta = '0;
    req.iter_restart = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_add_get();
    test_iterate();
    test_random_mix(600, 1'b0);
    test_long_stall();
    idle_on = 1'b0;
    test_random_mix(100, 1'b1);

    req.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ tuple_keyed_hash_accumulator.f @@
+incdir+rtl
rtl/thka_pkg.sv
rtl/thka_if.sv
rtl/thka_ram.sv
rtl/thka_hash.sv
rtl/tuple_keyed_hash_accumulator.sv
test/tuple_keyed_hash_accumulator_tb.sv
